// ===== design/rdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared types, codes and calendar tables for the recurring date rule resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdr_pkg;

	// rule kinds
	localparam logic [2:0] KIND_MONTH_DAY     = 3'd0;
	localparam logic [2:0] KIND_MONTHLY_DAY   = 3'd1;
	localparam logic [2:0] KIND_MONTH_WDAY    = 3'd2;
	localparam logic [2:0] KIND_MONTHLY_WDAY  = 3'd3;
	localparam logic [2:0] KIND_WEEK_WDAY     = 3'd4;
	localparam logic [2:0] KIND_YEAR_DAY      = 3'd5;

	// week numbering schemes
	localparam logic [1:0] WN_ISO      = 2'd0;
	localparam logic [1:0] WN_ISLAMIC  = 2'd1;
	localparam logic [1:0] WN_NORTH_AM = 2'd2;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_BAD_RULE = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_RULE_KIND        = 3'd0;
	localparam logic [2:0] CFG_RULE_MONTH       = 3'd1;
	localparam logic [2:0] CFG_RULE_DAY         = 3'd2;
	localparam logic [2:0] CFG_RULE_WEEKDAY     = 3'd3;
	localparam logic [2:0] CFG_RULE_DAY_ORDER   = 3'd4;
	localparam logic [2:0] CFG_RULE_WEEK_NUMBER = 3'd5;
	localparam logic [2:0] CFG_RULE_YEAR_DAY    = 3'd6;
	localparam logic [2:0] CFG_WEEK_NUMBERING   = 3'd7;

	// weekday codes used as week starts
	localparam logic [2:0] WD_SUNDAY   = 3'd0;
	localparam logic [2:0] WD_MONDAY   = 3'd1;
	localparam logic [2:0] WD_SATURDAY = 3'd6;

	// ISO week 1 holds this day of January
	localparam int WEEK_ANCHOR_ISO = 4;
	localparam logic [2:0] ISO_ANCHOR_OFS = 3'(WEEK_ANCHOR_ISO - 1);

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// x / 100 == (x * 5243) >> 19 for all 14-bit x
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	typedef struct packed {
		logic [2:0] rule_kind;
		logic [3:0] rule_month;
		logic [4:0] rule_day;
		logic [2:0] rule_weekday;
		logic [2:0] rule_day_order;
		logic [5:0] rule_week_number;
		logic [8:0] rule_year_day;
		logic [1:0] week_numbering;
	} rdr_cfg_t;

	// day of year (from 0) of the first of month m, common year
	function automatic logic [8:0] month_start(input logic [3:0] m);
		case (m)
			4'd1:    return 9'd0;
			4'd2:    return 9'd31;
			4'd3:    return 9'd59;
			4'd4:    return 9'd90;
			4'd5:    return 9'd120;
			4'd6:    return 9'd151;
			4'd7:    return 9'd181;
			4'd8:    return 9'd212;
			4'd9:    return 9'd243;
			4'd10:   return 9'd273;
			4'd11:   return 9'd304;
			4'd12:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

	// month_start modulo 7
	function automatic logic [2:0] month_start_mod7(input logic [3:0] m);
		case (m)
			4'd1:    return 3'd0;
			4'd2:    return 3'd3;
			4'd3:    return 3'd3;
			4'd4:    return 3'd6;
			4'd5:    return 3'd1;
			4'd6:    return 3'd4;
			4'd7:    return 3'd6;
			4'd8:    return 3'd2;
			4'd9:    return 3'd5;
			4'd10:   return 3'd0;
			4'd11:   return 3'd3;
			4'd12:   return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

	// month length, common year
	function automatic logic [4:0] month_len(input logic [3:0] m);
		case (m)
			4'd2:                      return 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        return 5'd31;
			default:                   return 5'd0;
		endcase
	endfunction

	function automatic logic [8:0] month_start_lp(input logic [3:0] m, input logic lp);
		return month_start(m) + {8'd0, (lp && (m > 4'd2))};
	endfunction

	// 14-bit value mod 7 by folding octal digits (8 == 1 mod 7)
	function automatic logic [2:0] mod7_14(input logic [13:0] x);
		logic [5:0] f1;
		logic [3:0] f2;
		logic [3:0] f3;
		f1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
			+ {4'd0, x[13:12]};
		f2 = {1'b0, f1[5:3]} + {1'b0, f1[2:0]};
		f3 = {3'd0, f2[3]} + {1'b0, f2[2:0]};
		return (f3 == 4'd7) ? 3'd0 : f3[2:0];
	endfunction

	function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
	endfunction

	function automatic logic [2:0] sub_mod7(input logic [2:0] a, input logic [2:0] b);
		return (a >= b) ? 3'(a - b) : 3'({1'b0, a} + 4'd7 - {1'b0, b});
	endfunction

endpackage

// ===== design/recurring_date_rule_resolver_top.sv =====
// ----------------------------------------------------------------------------
// recurring_date_rule_resolver_top
// A query is registered through stages s1 to s7; s7 drives the result.
// Throughput: one query per cycle; seven pipeline stages, one shared advance.
// A stalled result holds all stages; bubbles do not absorb the stall.
// Reset: async active low; clears stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recurring_date_rule_resolver_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// query channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [13:0] query_year,
	input  logic [3:0]  query_month,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [13:0] result_year,
	output logic [3:0]  result_month,
	output logic [4:0]  result_day
);
	import rdr_pkg::*;

	// The user must change configuration only while the pipe is empty; the block
	// does not enforce it. Every stage reads the live registers, not a copy.
	rdr_cfg_t cfg;

	rdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ------------------------------------------------------------------
	// Pipeline control: the whole pipe moves unless the output stage
	// holds a result that the sink refuses.
	// ------------------------------------------------------------------
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign en       = !(v_s7 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// rule weekday 7 aliases Sunday
	logic [2:0] rw7;
	assign rw7 = (cfg.rule_weekday == 3'd7) ? WD_SUNDAY : cfg.rule_weekday;

	// ------------------------------------------------------------------
	// Stage 1: year / 100 by reciprocal multiply.
	// ------------------------------------------------------------------
	logic [26:0] qprod;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [7:0]  qy_s1;

	assign qprod = 27'(query_year) * 27'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1  <= query_year;
			month_s1 <= query_month;
			qy_s1    <= qprod[26:DIV100_SHIFT];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: leap flags for this and the next year, and the weekday
	// sum of January 1. Since 365 == 1 mod 7 the weekday of Jan 1 is
	// (p + p/4 - p/100 + p/400 + 1) mod 7 with p = year - 1.
	// ------------------------------------------------------------------
	logic [13:0] hund2, p2, wsum2;
	logic [6:0]  ry2;
	logic [7:0]  qp2;
	logic        yok2, leap2, leapn2;

	logic [13:0] year_s2, wsum_s2;
	logic [3:0]  month_s2;
	logic        yok_s2, leap_s2, leapn_s2;

	always_comb begin
		hund2  = 14'(qy_s1) * 14'd100;
		ry2    = 7'(year_s1 - hund2);
		p2     = year_s1 - 14'd1;
		// (year-1)/100 only drops below year/100 on a century year
		qp2    = (ry2 == 7'd0) ? (qy_s1 - 8'd1) : qy_s1;
		wsum2  = p2 + {2'd0, p2[13:2]} - {6'd0, qp2} + {8'd0, qp2[7:2]} + 14'd1;
		yok2   = (year_s1 != 14'd0) && (year_s1 <= YEAR_MAX);
		leap2  = (year_s1[1:0] == 2'd0) && ((ry2 != 7'd0) || (qy_s1[1:0] == 2'd0));
		// year+1 is a century year when year ends in 99
		leapn2 = (year_s1[1:0] == 2'd3) && ((ry2 != 7'd99) || (qy_s1[1:0] == 2'd3));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			wsum_s2  <= wsum2;
			yok_s2   <= yok2;
			leap_s2  <= leap2;
			leapn_s2 <= leapn2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: weekday of Jan 1, month selection and checks, month
	// offset within the year, and the early status.
	// ------------------------------------------------------------------
	logic [3:0] m3;
	logic       mok3, lpm3, dbad3;
	logic [4:0] dim3;
	logic [8:0] moff3;
	logic [2:0] moff7_3;
	logic [1:0] st3;

	logic [13:0] year_s3;
	logic [2:0]  wdj_s3, moff7_s3;
	logic [8:0]  moff_s3;
	logic [4:0]  dim_s3;
	logic        leap_s3, leapn_s3;
	logic [1:0]  st_s3;

	always_comb begin
		m3      = (cfg.rule_kind inside {KIND_MONTH_DAY, KIND_MONTH_WDAY}) ?
			cfg.rule_month : month_s2;
		mok3    = (m3 >= 4'd1) && (m3 <= 4'd12);
		lpm3    = leap_s2 && (m3 > 4'd2);
		dim3    = month_len(m3) + {4'd0, (leap_s2 && (m3 == 4'd2))};
		moff3   = month_start_lp(m3, leap_s2);
		moff7_3 = add_mod7(month_start_mod7(m3), {2'd0, lpm3});
		dbad3   = (cfg.rule_day == 5'd0) || (cfg.rule_day > dim3);

		// rule errors win over date errors
		if (cfg.rule_kind > KIND_YEAR_DAY) begin
			st3 = ST_BAD_RULE;
		end else if ((cfg.rule_kind == KIND_WEEK_WDAY) &&
			!(cfg.week_numbering inside {WN_ISO, WN_ISLAMIC, WN_NORTH_AM})) begin
			st3 = ST_BAD_RULE;
		end else if (!yok_s2) begin
			st3 = ST_BAD_DATE;
		end else if ((cfg.rule_kind inside {KIND_MONTH_DAY, KIND_MONTHLY_DAY}) &&
			(!mok3 || dbad3)) begin
			st3 = ST_BAD_DATE;
		end else if ((cfg.rule_kind inside {KIND_MONTH_WDAY, KIND_MONTHLY_WDAY}) &&
			!mok3) begin
			st3 = ST_BAD_DATE;
		end else begin
			st3 = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s3  <= year_s2;
			wdj_s3   <= mod7_14(wsum_s2);
			moff_s3  <= moff3;
			moff7_s3 <= moff7_3;
			dim_s3   <= dim3;
			leap_s3  <= leap_s2;
			leapn_s3 <= leapn_s2;
			st_s3    <= st3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: weekday distances. delta is the step from the first of
	// the month to the target weekday; for week rules wa is how far the
	// anchor day lies past its week start, wb the target's place in the
	// week.
	// ------------------------------------------------------------------
	logic [2:0] adm1_4, fd4, wdm4, wda4;

	logic [13:0] year_s4;
	logic [8:0]  moff_s4;
	logic [4:0]  dim_s4;
	logic [2:0]  delta_s4, wa_s4, wb_s4;
	logic        leap_s4, leapn_s4;
	logic [1:0]  st_s4;

	always_comb begin
		adm1_4 = (cfg.week_numbering == WN_ISO) ? ISO_ANCHOR_OFS : 3'd0;
		case (cfg.week_numbering)
			WN_ISO:     fd4 = WD_MONDAY;
			WN_ISLAMIC: fd4 = WD_SATURDAY;
			default:    fd4 = WD_SUNDAY;
		endcase
		wdm4 = add_mod7(wdj_s3, moff7_s3);
		wda4 = add_mod7(wdj_s3, adm1_4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s4  <= year_s3;
			moff_s4  <= moff_s3;
			dim_s4   <= dim_s3;
			delta_s4 <= sub_mod7(rw7, wdm4);
			wa_s4    <= sub_mod7(wda4, fd4);
			wb_s4    <= sub_mod7(rw7, fd4);
			leap_s4  <= leap_s3;
			leapn_s4 <= leapn_s3;
			st_s4    <= st_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: signed day offset from Jan 1 of the query year. The range
	// is about -13..510, so the result lands in year-1, year or year+1.
	// ------------------------------------------------------------------
	logic signed [7:0] d5;
	logic [10:0]       off5;
	logic [2:0]        adm1_5;

	logic [13:0] year_s5;
	logic [10:0] off_s5;
	logic        leap_s5, leapn_s5;
	logic [1:0]  st_s5;

	always_comb begin
		adm1_5 = (cfg.week_numbering == WN_ISO) ? ISO_ANCHOR_OFS : 3'd0;
		d5 = $signed(8'({5'd0, delta_s4}) + 8'({5'd0, cfg.rule_day_order}) * 8'd7
			- 8'd7);
		// "last": back off a week when the fifth one leaves the month
		if ((cfg.rule_day_order == 3'd5) && (d5 >= $signed({3'd0, dim_s4}))) begin
			d5 = d5 - 8'sd7;
		end
		case (cfg.rule_kind)
			KIND_MONTH_DAY, KIND_MONTHLY_DAY:
				off5 = 11'(moff_s4) + 11'(cfg.rule_day) - 11'd1;
			KIND_MONTH_WDAY, KIND_MONTHLY_WDAY:
				off5 = 11'(moff_s4) + {{3{d5[7]}}, d5};
			KIND_WEEK_WDAY:
				off5 = 11'(adm1_5) - 11'(wa_s4) + 11'(cfg.rule_week_number) * 11'd7
					- 11'd7 + 11'(wb_s4);
			KIND_YEAR_DAY:
				off5 = 11'(cfg.rule_year_day) - 11'd1;
			default:
				off5 = 11'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s5  <= year_s4;
			off_s5   <= off5;
			leap_s5  <= leap_s4;
			leapn_s5 <= leapn_s4;
			st_s5    <= st_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: pick the result year and day of year, range check.
	// A negative offset is always in December of the year before, so it
	// decodes correctly against the common-year table.
	// ------------------------------------------------------------------
	logic [10:0] leny6;
	logic [13:0] yr6;
	logic [8:0]  doy6;
	logic        lp6;
	logic [1:0]  st6;

	logic [13:0] yr_s6;
	logic [8:0]  doy_s6;
	logic        lp_s6;
	logic [1:0]  st_s6;

	always_comb begin
		leny6 = 11'd365 + {10'd0, leap_s5};
		st6   = st_s5;
		if (off_s5[10]) begin
			yr6  = year_s5 - 14'd1;
			doy6 = 9'(off_s5 + 11'd365);
			lp6  = 1'b0;
			if ((st_s5 == ST_OK) && (year_s5 == 14'd1)) begin
				st6 = ST_BAD_DATE;
			end
		end else if (off_s5 >= leny6) begin
			yr6  = year_s5 + 14'd1;
			doy6 = 9'(off_s5 - leny6);
			lp6  = leapn_s5;
			if ((st_s5 == ST_OK) && (year_s5 == YEAR_MAX)) begin
				st6 = ST_BAD_DATE;
			end
		end else begin
			yr6  = year_s5;
			doy6 = off_s5[8:0];
			lp6  = leap_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yr_s6  <= yr6;
			doy_s6 <= doy6;
			lp_s6  <= lp6;
			st_s6  <= st6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: day of year to month and day; this is the output stage.
	// Errors force the date fields to zero.
	// ------------------------------------------------------------------
	logic [3:0] m7;
	logic [8:0] ms7;
	logic [4:0] day7;

	logic [1:0]  status_s7;
	logic [13:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;

	always_comb begin
		m7 = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (doy_s6 >= month_start_lp(4'(i), lp_s6)) begin
				m7 = 4'(i);
			end
		end
		ms7  = month_start_lp(m7, lp_s6);
		day7 = 5'(doy_s6 - ms7 + 9'd1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s7 <= st_s6;
			if (st_s6 == ST_OK) begin
				year_s7  <= yr_s6;
				month_s7 <= m7;
				day_s7   <= day7;
			end else begin
				year_s7  <= 14'd0;
				month_s7 <= 4'd0;
				day_s7   <= 5'd0;
			end
		end
	end

	assign out_valid    = v_s7;
	assign status       = status_s7;
	assign result_year  = year_s7;
	assign result_month = month_s7;
	assign result_day   = day_s7;

endmodule

// ===== design/rdr_cfg.sv =====
// ----------------------------------------------------------------------------
// rdr_cfg
// Rule configuration registers with plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [8:0]        cfg_data,
	output rdr_pkg::rdr_cfg_t cfg
);
	import rdr_pkg::*;

	rdr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rule_kind        <= KIND_MONTH_DAY;
			cfg_q.rule_month       <= 4'd1;
			cfg_q.rule_day         <= 5'd1;
			cfg_q.rule_weekday     <= 3'd0;
			cfg_q.rule_day_order   <= 3'd1;
			cfg_q.rule_week_number <= 6'd1;
			cfg_q.rule_year_day    <= 9'd1;
			cfg_q.week_numbering   <= WN_ISO;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RULE_KIND:        cfg_q.rule_kind        <= cfg_data[2:0];
				CFG_RULE_MONTH:       cfg_q.rule_month       <= cfg_data[3:0];
				CFG_RULE_DAY:         cfg_q.rule_day         <= cfg_data[4:0];
				CFG_RULE_WEEKDAY:     cfg_q.rule_weekday     <= cfg_data[2:0];
				CFG_RULE_DAY_ORDER:   cfg_q.rule_day_order   <= cfg_data[2:0];
				CFG_RULE_WEEK_NUMBER: cfg_q.rule_week_number <= cfg_data[5:0];
				CFG_RULE_YEAR_DAY:    cfg_q.rule_year_day    <= cfg_data[8:0];
				CFG_WEEK_NUMBERING:   cfg_q.week_numbering   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== tb/tb_recurring_date_rule_resolver_top.sv =====
// ----------------------------------------------------------------------------
// tb_recurring_date_rule_resolver_top
// Self-checking bench for the recurring date rule resolver. A calendar
// predictor tracks the rule registers and works out the date that each query
// transfer should resolve to. A checker compares every result transfer with
// the oldest pending date, field by field. Directed rules cover the calendar
// edge cases. After them come randomly drawn rules with random queries, under
// three idle and backpressure plans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_recurring_date_rule_resolver_top;

	import rdr_pkg::*;

	localparam int PIPE_DEPTH  = 7;     // pipeline stages in the DUT
	localparam int QUIET_LIMIT = 4000;  // quiet cycles before giving up

	typedef struct {
		logic [1:0]  status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_result_t;

	// DUT ports; every input starts at a known value
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [2:0]  cfg_index   = '0;
	logic [8:0]  cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [13:0] query_year  = '0;
	logic [3:0]  query_month = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  status;
	logic [13:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;

	// predictor's copy of the rule registers
	rdr_cfg_t     rule_cfg;
	// dates still owed by the DUT, oldest first
	date_result_t pending_dates[$];

	int mismatches    = 0;
	int quiet_cycles  = 0;
	// idle plan: percent of idle sender cycles, percent of stalled cycles
	int send_gap_pct  = 0;
	int stall_pct     = 0;

	recurring_date_rule_resolver_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.query_year   (query_year),
		.query_month  (query_month),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Calendar predictor
	// Day index 0 is 0001-01-01, a Monday. Weekdays run 0 Sunday .. 6 Saturday.
	// ------------------------------------------------------------------
	function automatic bit leap_year(longint y);
		return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
	endfunction

	function automatic longint month_days(longint y, int m);
		case (m)
			2:             return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	function automatic longint day_index(longint y, int m, longint d);
		longint p;
		longint n;
		p = y - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400;
		for (int k = 1; k < m; k++)
			n += month_days(y, k);
		return n + d - 1;
	endfunction

	function automatic int weekday_at(longint n);
		return int'((n + 1) % 7);
	endfunction

	function automatic date_result_t error_date(logic [1:0] code);
		date_result_t res;
		res.status = code;
		res.year   = '0;
		res.month  = '0;
		res.day    = '0;
		return res;
	endfunction

	// day index back to year/month/day; anything outside 0001..9999 is a bad date
	function automatic date_result_t date_from_index(longint n);
		date_result_t res;
		longint r;
		longint c400;
		longint c100;
		longint c4;
		longint c1;
		longint y;
		int     m;
		if (n < 0 || n >= day_index(10000, 1, 1))
			return error_date(ST_BAD_DATE);
		c400 = n / 146097;
		r    = n % 146097;
		c100 = r / 36524;
		if (c100 == 4)
			c100 = 3;
		r -= c100 * 36524;
		c4 = r / 1461;
		r  = r % 1461;
		c1 = r / 365;
		if (c1 == 4)
			c1 = 3;  // Dec 31 of a leap year
		r -= c1 * 365;
		y = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
		m = 1;
		while (m < 12 && r >= month_days(y, m)) begin
			r -= month_days(y, m);
			m++;
		end
		res.status = ST_OK;
		res.year   = 14'(y);
		res.month  = 4'(m);
		res.day    = 5'(r + 1);
		return res;
	endfunction

	// date that the current rule gives for one query
	function automatic date_result_t resolve_rule(logic [13:0] q_year, logic [3:0] q_month);
		longint y;
		int     m;
		int     wday;
		int     order;
		int     week_start;
		int     anchor;
		longint base;
		longint n;
		y          = longint'(q_year);
		wday       = int'(rule_cfg.rule_weekday);
		order      = int'(rule_cfg.rule_day_order);
		week_start = int'(WD_MONDAY);
		anchor     = 1;
		// rule errors win over any date error
		if (rule_cfg.rule_kind > KIND_YEAR_DAY)
			return error_date(ST_BAD_RULE);
		if (rule_cfg.rule_kind == KIND_WEEK_WDAY) begin
			case (rule_cfg.week_numbering)
				WN_ISO: begin
					week_start = int'(WD_MONDAY);
					anchor     = WEEK_ANCHOR_ISO;
				end
				WN_ISLAMIC: begin
					week_start = int'(WD_SATURDAY);
					anchor     = 1;
				end
				WN_NORTH_AM: begin
					week_start = int'(WD_SUNDAY);
					anchor     = 1;
				end
				default: return error_date(ST_BAD_RULE);
			endcase
		end
		if (y < 1 || y > longint'(YEAR_MAX))
			return error_date(ST_BAD_DATE);

		case (rule_cfg.rule_kind)
			KIND_MONTH_DAY, KIND_MONTHLY_DAY: begin
				m = (rule_cfg.rule_kind == KIND_MONTH_DAY) ? int'(rule_cfg.rule_month)
					: int'(q_month);
				if (m < 1 || m > 12 || rule_cfg.rule_day < 1 ||
				    longint'(rule_cfg.rule_day) > month_days(y, m))
					return error_date(ST_BAD_DATE);
				return date_from_index(day_index(y, m, longint'(rule_cfg.rule_day)));
			end
			KIND_MONTH_WDAY, KIND_MONTHLY_WDAY: begin
				m = (rule_cfg.rule_kind == KIND_MONTH_WDAY) ? int'(rule_cfg.rule_month)
					: int'(q_month);
				if (m < 1 || m > 12)
					return error_date(ST_BAD_DATE);
				base = day_index(y, m, 1);
				// order 0 lands a week before the first, 6 and 7 run past the month
				n = base + (wday + 7 - weekday_at(base)) % 7 + 7 * (order - 1);
				if (order == 5 && n >= base + month_days(y, m))
					n -= 7;  // "last" falls back to the fourth
				return date_from_index(n);
			end
			KIND_WEEK_WDAY: begin
				base = day_index(y, 1, anchor);
				base -= (weekday_at(base) + 7 - week_start) % 7;
				n = base + 7 * (longint'(rule_cfg.rule_week_number) - 1)
					+ (wday + 7 - week_start) % 7;
				return date_from_index(n);
			end
			default: begin
				n = day_index(y, 1, 1) + longint'(rule_cfg.rule_year_day) - 1;
				return date_from_index(n);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Every task starts and ends right after a rising edge.
	// ------------------------------------------------------------------

	// one register write; the predictor copy keeps only the register's width
	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_RULE_KIND:        rule_cfg.rule_kind        = val[2:0];
			CFG_RULE_MONTH:       rule_cfg.rule_month       = val[3:0];
			CFG_RULE_DAY:         rule_cfg.rule_day         = val[4:0];
			CFG_RULE_WEEKDAY:     rule_cfg.rule_weekday     = val[2:0];
			CFG_RULE_DAY_ORDER:   rule_cfg.rule_day_order   = val[2:0];
			CFG_RULE_WEEK_NUMBER: rule_cfg.rule_week_number = val[5:0];
			CFG_RULE_YEAR_DAY:    rule_cfg.rule_year_day    = val[8:0];
			CFG_WEEK_NUMBERING:   rule_cfg.week_numbering   = val[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one query transfer; valid stays high so back-to-back queries leave no bubble
	task automatic send_query(logic [13:0] q_year, logic [3:0] q_month);
		// each cycle idles with the plan's odds
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		query_year  <= q_year;
		query_month <= q_month;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_dates.push_back(resolve_rule(q_year, q_month));
	endtask

	// drop valid, let every owed date come back, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result checker: result transfers are matched in order
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		date_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dates.size() == 0) begin
				$error("unexpected result transfer: status %0d date %0d-%0d-%0d",
					status, result_year, result_month, result_day);
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (result_year !== want.year) begin
					$error("result_year: expected %0d, got %0d", want.year, result_year);
					mismatches++;
				end
				if (result_month !== want.month) begin
					$error("result_month: expected %0d, got %0d", want.month, result_month);
					mismatches++;
				end
				if (result_day !== want.day) begin
					$error("result_day: expected %0d, got %0d", want.day, result_day);
					mismatches++;
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: any transfer or register write counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// reset rule is January 1st; year field extremes, both legal and not
	task automatic test_default_rule();
		send_query(14'd1, 4'd1);
		send_query(14'd9999, 4'd12);
		send_query(14'd0, 4'd0);
		send_query(14'h3FFF, 4'hF);
		wait_idle();
	endtask

	// fixed month and day: leap day, short months, bad month and day 0
	task automatic test_month_day();
		write_reg(CFG_RULE_KIND, 9'(KIND_MONTH_DAY));
		write_reg(CFG_RULE_MONTH, 9'd2);
		write_reg(CFG_RULE_DAY, 9'd29);
		send_query(14'd2000, 4'd1);
		send_query(14'd1900, 4'd1);
		wait_idle();
		write_reg(CFG_RULE_MONTH, 9'd0);
		send_query(14'd2023, 4'd5);
		wait_idle();
		write_reg(CFG_RULE_MONTH, 9'd15);
		send_query(14'd2023, 4'd5);
		wait_idle();
		write_reg(CFG_RULE_MONTH, 9'd12);
		write_reg(CFG_RULE_DAY, 9'd0);
		send_query(14'd2023, 4'd5);
		wait_idle();
	endtask

	// day 31 in the queried month, including months out of range
	task automatic test_monthly_day();
		write_reg(CFG_RULE_KIND, 9'(KIND_MONTHLY_DAY));
		write_reg(CFG_RULE_DAY, 9'd31);
		send_query(14'd2024, 4'd0);
		send_query(14'd2024, 4'd1);
		send_query(14'd2024, 4'd6);
		send_query(14'd9999, 4'd12);
		send_query(14'd2024, 4'd15);
		wait_idle();
	endtask

	// nth weekday: order zero before year 1, weekday seven, last, overflow
	task automatic test_weekday_order();
		write_reg(CFG_RULE_KIND, 9'(KIND_MONTH_WDAY));
		write_reg(CFG_RULE_MONTH, 9'd1);
		write_reg(CFG_RULE_WEEKDAY, 9'd7);
		write_reg(CFG_RULE_DAY_ORDER, 9'd0);
		send_query(14'd1, 4'd1);
		send_query(14'd2024, 4'd1);
		wait_idle();
		write_reg(CFG_RULE_KIND, 9'(KIND_MONTHLY_WDAY));
		write_reg(CFG_RULE_WEEKDAY, 9'd4);
		write_reg(CFG_RULE_DAY_ORDER, 9'd5);
		send_query(14'd2024, 4'd2);
		send_query(14'd2024, 4'd13);
		wait_idle();
		write_reg(CFG_RULE_DAY_ORDER, 9'd7);
		send_query(14'd9999, 4'd12);
		wait_idle();
	endtask

	// week rules: week zero in year 1, the three numberings, bad numbering
	task automatic test_week_weekday();
		write_reg(CFG_RULE_KIND, 9'(KIND_WEEK_WDAY));
		write_reg(CFG_RULE_WEEKDAY, 9'd0);
		write_reg(CFG_RULE_WEEK_NUMBER, 9'd0);
		write_reg(CFG_WEEK_NUMBERING, 9'(WN_ISO));
		send_query(14'd1, 4'd3);
		wait_idle();
		write_reg(CFG_WEEK_NUMBERING, 9'(WN_ISLAMIC));
		write_reg(CFG_RULE_WEEK_NUMBER, 9'd1);
		write_reg(CFG_RULE_WEEKDAY, 9'd6);
		send_query(14'd1, 4'd3);
		wait_idle();
		write_reg(CFG_WEEK_NUMBERING, 9'(WN_NORTH_AM));
		write_reg(CFG_RULE_WEEK_NUMBER, 9'd63);
		send_query(14'd9999, 4'd3);
		wait_idle();
		write_reg(CFG_WEEK_NUMBERING, 9'd3);
		send_query(14'd2024, 4'd3);
		wait_idle();
	endtask

	// day of year: zero rolls back a year, large values roll forward
	task automatic test_year_day();
		write_reg(CFG_RULE_KIND, 9'(KIND_YEAR_DAY));
		write_reg(CFG_RULE_YEAR_DAY, 9'd0);
		send_query(14'd1, 4'd1);
		send_query(14'd2000, 4'd1);
		wait_idle();
		write_reg(CFG_RULE_YEAR_DAY, 9'd366);
		send_query(14'd2023, 4'd1);
		wait_idle();
		write_reg(CFG_RULE_YEAR_DAY, 9'd511);
		send_query(14'd9999, 4'd1);
		wait_idle();
	endtask

	// unknown kinds report a bad rule even for a bad year
	task automatic test_bad_kind();
		write_reg(CFG_RULE_KIND, 9'd6);
		send_query(14'd0, 4'd1);
		wait_idle();
		write_reg(CFG_RULE_KIND, 9'd7);
		send_query(14'd2024, 4'd1);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Random rules and queries
	// ------------------------------------------------------------------

	// mostly in range, some range ends, now and then raw 9-bit junk
	function automatic logic [8:0] pick_reg(int lo, int hi);
		case ($urandom_range(0, 15))
			0:       return 9'($urandom_range(0, 511));
			1:       return 9'(lo);
			2:       return 9'(hi);
			default: return 9'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [13:0] pick_year();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(10000, 16383));
			1:       return 14'($urandom_range(1, 3));
			2:       return 14'($urandom_range(9997, 9999));
			default: return 14'($urandom_range(1, 9999));
		endcase
	endfunction

	task automatic test_random_rules();
		logic [3:0] q_month;
		for (int plan = 0; plan < 3; plan++) begin
			// sender-light/receiver-heavy, then swapped, then no idling
			case (plan)
				0:       begin send_gap_pct = 10; stall_pct = 59; end
				1:       begin send_gap_pct = 59; stall_pct = 10; end
				default: begin send_gap_pct = 0;  stall_pct = 0;  end
			endcase
			repeat (18) begin
				write_reg(CFG_RULE_KIND,        pick_reg(0, 5));
				write_reg(CFG_RULE_MONTH,       pick_reg(1, 12));
				write_reg(CFG_RULE_DAY,         pick_reg(1, 31));
				write_reg(CFG_RULE_WEEKDAY,     pick_reg(0, 7));
				write_reg(CFG_RULE_DAY_ORDER,   pick_reg(0, 7));
				write_reg(CFG_RULE_WEEK_NUMBER, pick_reg(0, 53));
				write_reg(CFG_RULE_YEAR_DAY,    pick_reg(0, 366));
				write_reg(CFG_WEEK_NUMBERING,   pick_reg(0, 2));
				repeat (30) begin
					q_month = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 12));
					send_query(pick_year(), q_month);
				end
				wait_idle();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		rule_cfg = '{KIND_MONTH_DAY, 4'd1, 5'd1, 3'd0, 3'd1, 6'd1, 9'd1, WN_ISO};
		send_gap_pct = 10;
		stall_pct    = 59;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_rule();
		test_month_day();
		test_monthly_day();
		test_weekday_order();
		test_week_weekday();
		test_year_day();
		test_bad_kind();
		test_random_rules();

		if (mismatches == 0 && pending_dates.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
